// ===== hdl/baf_pkg.sv =====
// Shared types and constants for the bump allocator with a free list.
`default_nettype none

package baf_pkg;

  // Operation codes carried on the mode field.
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OOM  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned OffW  = 20;
  localparam int unsigned SizeW = 21;

  // Bump pointer alignment; must be a power of two.
  localparam int unsigned Align = 8;

  // Reset value of the pool size register.
  localparam logic [SizeW-1:0] PoolSizeReset = 21'd1048576;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and its table match
    logic commit;  // update state and load the result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/baf_ctrl.sv =====
// Controller state machine: request handshake, execute step and result valid.
`default_nettype none

module baf_ctrl
  import baf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output ctl_cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  // A request is taken only in idle; the execute step waits for a free result slot.
  always_comb begin
    in_ready_o   = (state_q == StIdle);
    cmd_o.load   = in_valid_i && (state_q == StIdle);
    cmd_o.commit = (state_q == StExec) && (!out_valid_q || out_ready_i);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.load) state_d = StExec;
      end
      StExec: begin
        if (cmd_o.commit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // The result register is full from commit until the consumer takes it.
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/baf_dp.sv =====
// Datapath: pool register, bump pointer, free table with first-fit match, result register.
`default_nettype none

module baf_dp
  import baf_pkg::*;
#(
  parameter int unsigned     FREE_SLOTS = 16,
  parameter int unsigned     MIN_BLOCK  = 16,
  parameter longint unsigned MAX_POOL   = 1048576
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctl_cmd_t         cmd_i,
  input  wire logic             cfg_we_i,
  input  wire logic [SizeW-1:0] pool_size_i,
  input  wire logic [1:0]       mode_i,
  input  wire logic [OffW-1:0]  block_offset_i,
  input  wire logic             is_null_i,
  input  wire logic [SizeW-1:0] request_size_i,
  output logic [SizeW-1:0]      result_offset_o,
  output logic [1:0]            status_o,
  output logic [SizeW-1:0]      bump_level_o,
  output logic [SizeW-1:0]      free_bytes_o
);

  localparam int unsigned CntW = $clog2(FREE_SLOTS + 1);
  localparam int unsigned IdxW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam logic [SizeW:0] AlignMask = (SizeW + 1)'(Align - 1);

  // Configuration and allocator state.
  logic [SizeW-1:0] pool_q;
  logic [SizeW-1:0] bump_q, bump_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [OffW-1:0]  start_q [FREE_SLOTS];
  logic [SizeW-1:0] len_q   [FREE_SLOTS];

  // Captured request.
  logic [1:0]       mode_q;
  logic [OffW-1:0]  boff_q;
  logic             null_q;
  logic [SizeW-1:0] size_q;
  logic             hit_q;
  logic [IdxW-1:0]  idx_q;

  // Result register.
  logic [SizeW-1:0] res_q, res_d;
  logic [1:0]       status_q, status_d;
  logic [SizeW-1:0] used_q;
  logic [SizeW-1:0] free_q, free_d;

  logic [SizeW-1:0] size_in;
  logic             hit_in;
  logic [IdxW-1:0]  idx_in;
  logic [SizeW-1:0] pool;
  logic [SizeW:0]   aligned;
  logic [SizeW+1:0] alloc_end;
  logic             alloc_fit;
  logic             rewind;
  logic             push;
  logic             remove;

  // Sizes below the minimum block are raised; zero stays zero.
  always_comb begin
    if ((request_size_i != '0) && (request_size_i < SizeW'(MIN_BLOCK))) begin
      size_in = SizeW'(MIN_BLOCK);
    end else begin
      size_in = request_size_i;
    end
  end

  // First-fit match: the highest valid slot, being the most recently freed, wins.
  always_comb begin
    hit_in = 1'b0;
    idx_in = '0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if ((CntW'(i) < count_q) && (len_q[i] >= size_in)) begin
        hit_in = 1'b1;
        idx_in = IdxW'(i);
      end
    end
  end

  // Pool in effect is capped by the largest supported pool.
  always_comb begin
    if (64'(pool_q) > 64'(MAX_POOL)) begin
      pool = SizeW'(MAX_POOL);
    end else begin
      pool = pool_q;
    end
  end

  // Bump allocation arithmetic.
  always_comb begin
    aligned   = ({1'b0, bump_q} + AlignMask) & ~AlignMask;
    alloc_end = {1'b0, aligned} + {2'b00, size_q};
    alloc_fit = alloc_end <= {2'b00, pool};
    rewind    = ({2'b00, boff_q} + {1'b0, size_q}) == {1'b0, bump_q};
  end

  // Step evaluation.
  always_comb begin
    bump_d   = bump_q;
    count_d  = count_q;
    res_d    = '0;
    status_d = STATUS_OK;
    push     = 1'b0;
    remove   = 1'b0;
    case (mode_q)
      MODE_ALLOC: begin
        if (hit_q) begin
          res_d   = {1'b0, start_q[idx_q]};
          count_d = count_q - CntW'(1);
          remove  = 1'b1;
        end else if (alloc_fit) begin
          bump_d = alloc_end[SizeW-1:0];
          res_d  = aligned[SizeW-1:0];
        end else begin
          status_d = STATUS_OOM;
        end
      end
      MODE_FREE: begin
        if (!null_q && (size_q != '0)) begin
          if (rewind) begin
            bump_d = {1'b0, boff_q};
          end else if (count_q >= CntW'(FREE_SLOTS)) begin
            status_d = STATUS_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            push    = 1'b1;
          end
        end
      end
      MODE_RESET: begin
        bump_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (bump_d > pool) begin
      free_d = '0;
    end else begin
      free_d = pool - bump_d;
    end
  end

  // Control state: pool register, bump pointer and table fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= PoolSizeReset;
      bump_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) pool_q <= pool_size_i;
      if (cmd_i.commit) begin
        bump_q  <= bump_d;
        count_q <= count_d;
      end
    end
  end

  // Captured request and match result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      boff_q <= block_offset_i;
      null_q <= is_null_i;
      size_q <= size_in;
      hit_q  <= hit_in;
      idx_q  <= idx_in;
    end
  end

  // Free table: removal closes the gap by shifting newer entries down; a push
  // writes the slot just above the newest one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int j = 0; j < FREE_SLOTS; j++) begin
        if (push && (count_q == CntW'(j))) begin
          start_q[j] <= boff_q;
          len_q[j]   <= size_q;
        end
      end
      for (int j = 0; j + 1 < FREE_SLOTS; j++) begin
        if (remove && (IdxW'(j) >= idx_q) && (CntW'(j + 1) < count_q)) begin
          start_q[j] <= start_q[j+1];
          len_q[j]   <= len_q[j+1];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q    <= res_d;
      status_q <= status_d;
      used_q   <= bump_d;
      free_q   <= free_d;
    end
  end

  assign result_offset_o = res_q;
  assign status_o        = status_q;
  assign bump_level_o    = used_q;
  assign free_bytes_o    = free_q;

endmodule

`default_nettype wire

// ===== hdl/bump_allocator_with_free_list.sv =====
// Top level of the bump allocator with a most-recent-first free list.
//
//   Channel  Handshake               Payload
//   in       in_valid_i/in_ready_o   mode_i, block_offset_i, is_null_i, request_size_i
//   out      out_valid_o/out_ready_i result_offset_o, status_o, bump_level_o, free_bytes_o
//   cfg      cfg_valid_i/cfg_ready_o pool_size_i
//
// A request passes the idle and execute states: the accept cycle compares every
// free-table slot against the raised size and registers the first fit, and the execute
// state then commits the state update into the result register. A new request is taken
// once that commit is done, even while the previous result still waits on out_ready_i;
// the commit itself waits while the result register is full. Reset empties the free
// table, clears the bump pointer and sets the pool size to 1048576 bytes.
`default_nettype none

module bump_allocator_with_free_list
  import baf_pkg::*;
#(
  parameter int unsigned     FREE_SLOTS = 16,
  parameter int unsigned     MIN_BLOCK  = 16,
  parameter longint unsigned MAX_POOL   = 1048576
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [OffW-1:0]  block_offset_i,
  input  wire logic             is_null_i,
  input  wire logic [SizeW-1:0] request_size_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [SizeW-1:0]      result_offset_o,
  output logic [1:0]            status_o,
  output logic [SizeW-1:0]      bump_level_o,
  output logic [SizeW-1:0]      free_bytes_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [SizeW-1:0] pool_size_i
);

  ctl_cmd_t cmd;

  // The pool size register always takes a write.
  assign cfg_ready_o = 1'b1;

  baf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  baf_dp #(
    .FREE_SLOTS (FREE_SLOTS),
    .MIN_BLOCK  (MIN_BLOCK),
    .MAX_POOL   (MAX_POOL)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i),
    .pool_size_i     (pool_size_i),
    .mode_i          (mode_i),
    .block_offset_i  (block_offset_i),
    .is_null_i       (is_null_i),
    .request_size_i  (request_size_i),
    .result_offset_o (result_offset_o),
    .status_o        (status_o),
    .bump_level_o    (bump_level_o),
    .free_bytes_o    (free_bytes_o)
  );

endmodule

`default_nettype wire
